FILE: design/priority_ready_queue_assert.svh
// ---------------------------------------------------------------------------
// priority ready queue assertion macros
// concurrent checks on clk_i, switched off as a group by NO_ASSERTIONS
// ---------------------------------------------------------------------------
`ifndef PRIORITY_READY_QUEUE_ASSERT_SVH
`define PRIORITY_READY_QUEUE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// checked outside reset only
`define PRQ_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("priority_ready_queue check failed");

// checked during reset as well
`define PRQ_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("priority_ready_queue check failed");

`else

`define PRQ_ASSERT(label, prop)
`define PRQ_ASSERT_ALWAYS(label, prop)

`endif

`endif

FILE: design/prq_pkg.sv
// ---------------------------------------------------------------------------
// prq_pkg
// shared types and codes of the priority ready queue
// ---------------------------------------------------------------------------
package prq_pkg;

  localparam int ID_W     = 8;
  localparam int PRIO_W   = 8;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 5;

  // request commands
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_POP    = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  typedef struct packed {
    logic              cmd;
    logic [ID_W-1:0]   thread_id;
    logic [PRIO_W-1:0] prio;
  } req_t;

  typedef struct packed {
    logic [ID_W-1:0]     popped_id;
    logic [PRIO_W-1:0]   popped_prio;
    logic [STATUS_W-1:0] status;
    logic [OCC_W-1:0]    occupancy;
  } res_t;

endpackage

FILE: design/prq_in_if.sv
// ---------------------------------------------------------------------------
// prq_in_if
// request channel: insert or pop command with thread identifier and priority
// ---------------------------------------------------------------------------
interface prq_in_if import prq_pkg::*;;
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [ID_W-1:0]   thread_id;
  logic [PRIO_W-1:0] prio;

  modport source (output valid, output cmd, output thread_id, output prio, input ready);
  modport sink   (input valid, input cmd, input thread_id, input prio, output ready);
endinterface

FILE: design/prq_out_if.sv
// ---------------------------------------------------------------------------
// prq_out_if
// result channel: popped entry, status and occupancy
// ---------------------------------------------------------------------------
interface prq_out_if import prq_pkg::*;;
  logic                valid;
  logic                ready;
  logic [ID_W-1:0]     popped_id;
  logic [PRIO_W-1:0]   popped_prio;
  logic [STATUS_W-1:0] status;
  logic [OCC_W-1:0]    occupancy;

  modport source (output valid, output popped_id, output popped_prio, output status,
                  output occupancy, input ready);
  modport sink   (input valid, input popped_id, input popped_prio, input status,
                  input occupancy, output ready);
endinterface

FILE: design/prq_ram.sv
// ---------------------------------------------------------------------------
// prq_ram
// generic simple dual-port ram, one write and one registered read per cycle
// ---------------------------------------------------------------------------
module prq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: design/prq_ctrl.sv
// ---------------------------------------------------------------------------
// prq_ctrl
// sequencer of the queue: circular head pointer, entry count and an insertion
// walk that moves one lower-priority entry back per step through the ram
// ---------------------------------------------------------------------------
module prq_ctrl import prq_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           req_valid_i,
  output logic                           req_ready_o,
  input  req_t                           req_i,
  output logic                           res_valid_o,
  input  logic                           res_ready_i,
  output res_t                           res_o,
  output logic                           ram_we_o,
  output logic [$clog2(QUEUE_DEPTH)-1:0] ram_addr_o,
  output entry_t                         ram_wdata_o,
  input  entry_t                         ram_rdata_i
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [AW:0]   DEPTH_A = (AW+1)'(QUEUE_DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_POP     = 3'd1;
  localparam logic [2:0] ST_INS_RD  = 3'd2;
  localparam logic [2:0] ST_INS_CMP = 3'd3;
  localparam logic [2:0] ST_INS_PUT = 3'd4;
  localparam logic [2:0] ST_RESP    = 3'd5;

  logic [2:0]          state_q, state_d;
  logic [AW-1:0]       head_q, head_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [AW-1:0]       k_q, k_d;
  req_t                req_q, req_d;
  logic [ID_W-1:0]     rid_q, rid_d;
  logic [PRIO_W-1:0]   rprio_q, rprio_d;
  logic [STATUS_W-1:0] rstat_q, rstat_d;

  logic [AW-1:0]       off;
  logic [AW:0]         sum;
  logic [AW-1:0]       addr;
  logic [CW+OCC_W-1:0] occ_ext;

  // shared address unit: slot offset from the head, wrapped at the depth
  always_comb begin
    case (state_q)
      ST_INS_RD:              off = k_q - AW'(1);
      ST_INS_CMP, ST_INS_PUT: off = k_q;
      ST_POP:                 off = AW'(1);
      default:                off = '0;
    endcase
  end

  assign sum  = {1'b0, head_q} + {1'b0, off};
  assign addr = (sum >= DEPTH_A) ? AW'(sum - DEPTH_A) : sum[AW-1:0];

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    cnt_d       = cnt_q;
    k_d         = k_q;
    req_d       = req_q;
    rid_d       = rid_q;
    rprio_d     = rprio_q;
    rstat_d     = rstat_q;
    ram_we_o    = 1'b0;
    ram_wdata_o = '{id: req_q.thread_id, prio: req_q.prio};

    case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          req_d   = req_i;
          rid_d   = '0;
          rprio_d = '0;
          rstat_d = STAT_OK;
          if (req_i.cmd == CMD_POP) begin
            if (cnt_q == '0) begin
              rstat_d = STAT_EMPTY;
              state_d = ST_RESP;
            end else begin
              state_d = ST_POP;
            end
          end else if (cnt_q == DEPTH_C) begin
            rstat_d = STAT_FULL;
            state_d = ST_RESP;
          end else if (cnt_q == '0) begin
            k_d     = '0;
            state_d = ST_INS_PUT;
          end else begin
            k_d     = cnt_q[AW-1:0];
            state_d = ST_INS_RD;
          end
        end
      end
      ST_POP: begin
        rid_d   = ram_rdata_i.id;
        rprio_d = ram_rdata_i.prio;
        head_d  = addr;
        cnt_d   = cnt_q - CW'(1);
        state_d = ST_RESP;
      end
      ST_INS_RD: begin
        state_d = ST_INS_CMP;
      end
      ST_INS_CMP: begin
        ram_we_o = 1'b1;
        if (ram_rdata_i.prio < req_q.prio) begin
          // lower priority entry moves one slot back
          ram_wdata_o = ram_rdata_i;
          k_d         = k_q - AW'(1);
          state_d     = (k_q == AW'(1)) ? ST_INS_PUT : ST_INS_RD;
        end else begin
          cnt_d   = cnt_q + CW'(1);
          state_d = ST_RESP;
        end
      end
      ST_INS_PUT: begin
        ram_we_o = 1'b1;
        cnt_d    = cnt_q + CW'(1);
        state_d  = ST_RESP;
      end
      ST_RESP: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      head_q  <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q     <= k_d;
    req_q   <= req_d;
    rid_q   <= rid_d;
    rprio_q <= rprio_d;
    rstat_q <= rstat_d;
  end

  assign occ_ext     = {{OCC_W{1'b0}}, cnt_q};
  assign req_ready_o = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_RESP);
  assign ram_addr_o  = addr;
  assign res_o       = '{popped_id:   rid_q,
                         popped_prio: rprio_q,
                         status:      rstat_q,
                         occupancy:   occ_ext[OCC_W-1:0]};

endmodule

FILE: design/priority_ready_queue.sv
// ---------------------------------------------------------------------------
// priority_ready_queue
// Bounded stable priority queue of thread identifiers, higher priority first
// and equal priorities in arrival order. Entries sit in a ram used as a
// circular buffer behind a head pointer. One request is handled at a time.
// With the output register free, a pop passes through the pop and response
// states, and a pop on an empty queue or an insert into a full queue goes
// straight to the response state. An insert walks back from the tail over
// the lower-priority entries, each costing one registered ram read and one
// compare-and-write through the single address and priority compare unit,
// and writes the new entry on the first equal or higher one or in a put step.
// A result waits in an output register, so the next request can be taken
// while it is still unclaimed; a further result holds the sequencer in its
// response state until that register is taken.
// ---------------------------------------------------------------------------
`include "priority_ready_queue_assert.svh"

module priority_ready_queue import prq_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  prq_in_if.sink   in_i,
  prq_out_if.source out_o
);

  localparam int AW = $clog2(QUEUE_DEPTH);

  req_t          req;
  res_t          res;
  logic          res_valid;
  logic          res_take;
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  entry_t        ram_wdata;
  entry_t        ram_rdata;
  logic          out_valid_q;
  res_t          out_q;

  assign req = '{cmd: in_i.cmd, thread_id: in_i.thread_id, prio: in_i.prio};

  prq_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_i.valid),
    .req_ready_o (in_i.ready),
    .req_i       (req),
    .res_valid_o (res_valid),
    .res_ready_i (res_take),
    .res_o       (res),
    .ram_we_o    (ram_we),
    .ram_addr_o  (ram_addr),
    .ram_wdata_o (ram_wdata),
    .ram_rdata_i (ram_rdata)
  );

  prq_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_addr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_addr),
    .rdata_o (ram_rdata)
  );

  // output register, refilled as soon as it empties or is being taken
  assign res_take = res_valid && (!out_valid_q || out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_q <= res;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.popped_id   = out_q.popped_id;
  assign out_o.popped_prio = out_q.popped_prio;
  assign out_o.status      = out_q.status;
  assign out_o.occupancy   = out_q.occupancy;

  `PRQ_ASSERT(a_ready_excl_result, !(in_i.ready && res_valid))
  `PRQ_ASSERT(a_take_fills_output, res_take |=> out_o.valid && $past(res) == out_q)
  `PRQ_ASSERT(a_empty_pop_clean, res_valid && res.status == STAT_EMPTY |-> res.popped_id == '0 && res.popped_prio == '0 && res.occupancy == '0)
  `PRQ_ASSERT(a_out_hold, out_o.valid && !out_o.ready |=> out_o.valid && $stable(out_q))

endmodule
